@@ hw/rtl/hrss_pkg.sv @@
// Shared types and constants for the heater relay/SSR sequencer.
// No dependencies; every other file in hw/rtl refers to this package by scoped names.
package hrss_pkg;

    // Opcodes of an input word
    typedef logic [1:0] t_op;
    localparam t_op OP_SET   = 2'd0;
    localparam t_op OP_TICK  = 2'd1;
    localparam t_op OP_ABORT = 2'd2;

    // Configuration register indexes
    typedef logic [0:0] t_cfg_idx;
    localparam t_cfg_idx REG_RELAY_DELAY = 1'b0;
    localparam t_cfg_idx REG_ABORT_WAIT  = 1'b1;

    localparam int CFG_DATA_W = 16;

    typedef logic [6:0]  t_pct;
    typedef logic [15:0] t_delay;
    typedef logic [7:0]  t_wait;

    localparam t_pct   LEVEL_MAX          = 7'd100;
    localparam t_delay RELAY_DELAY_RESET  = 16'd20;
    localparam t_wait  ABORT_WAIT_RESET   = 8'd11;

    typedef struct packed {
        t_pct   commanded;
        t_pct   applied;
        logic   trans;
        t_delay delay_cnt;
        logic   relay;
        t_pct   ssr;
        logic   aborted;
        t_wait  abort_cnt;
    } t_state;

    localparam t_state STATE_RESET = '{
        commanded: '0, applied: '0, trans: 1'b0, delay_cnt: '0,
        relay: 1'b0, ssr: '0, aborted: 1'b0, abort_cnt: '0
    };

endpackage

@@ hw/rtl/hrss_if.sv @@
// Valid/ready channel interfaces for the sequencer's input and result words.
// Depends on hrss_pkg.
interface hrss_in_if;
    logic             valid;
    logic             ready;
    hrss_pkg::t_op    op;
    logic [7:0]       level;

    modport source (output valid, output op, output level, input ready);
    modport sink   (input valid, input op, input level, output ready);
endinterface

interface hrss_out_if;
    logic             valid;
    logic             ready;
    logic             relay_on;
    hrss_pkg::t_pct   ssr_duty;
    hrss_pkg::t_pct   commanded;
    logic             in_transition;
    logic             locked_out;

    modport source (output valid, output relay_on, output ssr_duty, output commanded,
                    output in_transition, output locked_out, input ready);
    modport sink   (input valid, input relay_on, input ssr_duty, input commanded,
                    input in_transition, input locked_out, output ready);
endinterface

@@ hw/rtl/heater_relay_ssr_sequencer.sv @@
// Top level of the heater relay/SSR sequencer: channel handshakes, config registers,
// sequencer state. Depends on hrss_pkg, hrss_if.sv and hrss_step.

// Drives a mains relay in series with a PWM solid-state relay. Each input word is
// a set (power 0..100, higher saturates), a 1 ms tick or an abort; each word yields
// exactly one result word with the relay drive, applied SSR duty, commanded level,
// transition flag and lockout flag as they stand after that word. Throughput is one
// word per clock while result ready stays high; an accepted word sits in the input
// register, then the combinational next-state logic loads the result register once the
// result register is free. While a result waits, the input register takes
// one more word and holds it until the result register frees; input ready follows
// result ready in the same cycle. Write relay_delay_ticks (index 0) and
// abort_wait_ticks (index 1) only while no word is in flight.
module heater_relay_ssr_sequencer (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    hrss_in_if.sink                           i_item,
    hrss_out_if.source                        o_result,
    input  logic                              i_cfg_we,
    input  hrss_pkg::t_cfg_idx                i_cfg_idx,
    input  logic [hrss_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    // config registers
    hrss_pkg::t_delay r_relay_delay;
    hrss_pkg::t_wait  r_abort_wait;

    // input stage
    logic             r_in_valid;
    hrss_pkg::t_op    r_in_op;
    logic [7:0]       r_in_level;

    // sequencer state and result stage
    hrss_pkg::t_state r_state;
    hrss_pkg::t_state n_state;
    logic             r_out_valid;

    logic advance;
    logic in_take;

    // move the held word into the result stage when the result register frees
    assign advance = r_in_valid && (!r_out_valid || o_result.ready);
    assign i_item.ready = !r_in_valid || advance;
    assign in_take = i_item.valid && i_item.ready;

    hrss_step u_step (
        .i_state       (r_state),
        .i_op          (r_in_op),
        .i_level       (r_in_level),
        .i_relay_delay (r_relay_delay),
        .i_abort_wait  (r_abort_wait),
        .o_state       (n_state)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_relay_delay <= hrss_pkg::RELAY_DELAY_RESET;
            r_abort_wait  <= hrss_pkg::ABORT_WAIT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                hrss_pkg::REG_RELAY_DELAY: r_relay_delay <= i_cfg_data;
                hrss_pkg::REG_ABORT_WAIT:  r_abort_wait  <= i_cfg_data[7:0];
                default:                   r_abort_wait  <= r_abort_wait;
            endcase
        end
    end

    // capture the incoming word; payload needs no reset
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_op    <= i_item.op;
            r_in_level <= i_item.level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= hrss_pkg::STATE_RESET;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                // the state register doubles as the result register
                r_state     <= n_state;
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_result.valid         = r_out_valid;
    assign o_result.relay_on      = r_state.relay;
    assign o_result.ssr_duty      = r_state.ssr;
    assign o_result.commanded     = r_state.commanded;
    assign o_result.in_transition = r_state.trans;
    assign o_result.locked_out    = r_state.aborted;

endmodule

@@ hw/rtl/hrss_step.sv @@
// Next-state logic of the sequencer for one input word (purely combinational).
// Depends on hrss_pkg.
module hrss_step (
    input  hrss_pkg::t_state i_state,
    input  hrss_pkg::t_op    i_op,
    input  logic [7:0]       i_level,
    input  hrss_pkg::t_delay i_relay_delay,
    input  hrss_pkg::t_wait  i_abort_wait,
    output hrss_pkg::t_state o_state
);

    hrss_pkg::t_pct lvl;
    logic           old_on;
    logic           new_on;

    assign lvl    = (i_level > {1'b0, hrss_pkg::LEVEL_MAX}) ? hrss_pkg::LEVEL_MAX
                                                           : i_level[6:0];
    assign old_on = (i_state.applied != '0);
    assign new_on = (lvl != '0);

    always_comb begin
        o_state = i_state;
        case (i_op)
            hrss_pkg::OP_SET: begin
                if (!i_state.aborted) begin
                    o_state.commanded = lvl;
                    o_state.applied   = lvl;
                    o_state.trans     = (old_on != new_on);
                    if (old_on != new_on) begin
                        o_state.delay_cnt = i_relay_delay;
                        o_state.ssr       = '0;
                        if (new_on) begin
                            o_state.relay = 1'b1;
                        end
                    end else begin
                        o_state.ssr = lvl;
                    end
                end
            end
            hrss_pkg::OP_TICK: begin
                if (i_state.trans) begin
                    if (i_state.delay_cnt > 16'd1) begin
                        o_state.delay_cnt = i_state.delay_cnt - 16'd1;
                    end else begin
                        // delay expired: finish the transition
                        o_state.delay_cnt = '0;
                        o_state.trans     = 1'b0;
                        if (i_state.commanded != '0) begin
                            o_state.ssr = i_state.applied;
                        end else begin
                            o_state.relay = 1'b0;
                        end
                    end
                end
                if (i_state.abort_cnt != '0) begin
                    o_state.abort_cnt = i_state.abort_cnt - 8'd1;
                    if (i_state.abort_cnt == 8'd1) begin
                        o_state.relay = 1'b0;
                    end
                end
            end
            hrss_pkg::OP_ABORT: begin
                o_state.commanded = '0;
                o_state.applied   = '0;
                o_state.ssr       = '0;
                o_state.trans     = 1'b0;
                o_state.delay_cnt = '0;
                o_state.aborted   = 1'b1;
                if ((i_state.commanded != '0) && (i_abort_wait != '0)) begin
                    o_state.abort_cnt = i_abort_wait;
                end else begin
                    o_state.abort_cnt = '0;
                    o_state.relay     = 1'b0;
                end
            end
            default: begin
                o_state = i_state;
            end
        endcase
    end

endmodule
